// File: rtl/pciag_pkg.sv
// Package with types, codes and helpers of the PC-indexed address generator.
`timescale 1ns / 1ps

package pciag_pkg;

	// Operation codes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_DELIVER = 1'b1;

	// Address kinds
	localparam logic KIND_FINAL = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Error codes
	localparam logic [1:0] ERR_NONE         = 2'd0;
	localparam logic [1:0] ERR_RESERVED_SEL = 2'd1;
	localparam logic [1:0] ERR_STRAY_DATA   = 2'd2;

	// Displacement size codes (base size field and low bits of the selection)
	localparam logic [1:0] DSZ_RESERVED = 2'd0;
	localparam logic [1:0] DSZ_NULL     = 2'd1;
	localparam logic [1:0] DSZ_WORD     = 2'd2;
	localparam logic [1:0] DSZ_LONG     = 2'd3;

	// Index/indirect selection codes with special meaning
	localparam logic [2:0] SEL_NO_INDIRECT = 3'd0;
	localparam logic [2:0] SEL_RESERVED    = 3'd4;

	// Extension word bit positions
	localparam int EXT_IDX_SIZE  = 11;
	localparam int EXT_FULL      = 8;
	localparam int EXT_BASE_SUPP = 7;
	localparam int EXT_IDX_SUPP  = 6;

	// Instruction stream byte counts
	localparam logic [3:0] BYTES_EXT  = 4'd2;
	localparam logic [3:0] BYTES_WORD = 4'd2;
	localparam logic [3:0] BYTES_LONG = 4'd4;

	localparam logic [31:0] LOW_WORD_MASK = 32'h0000FFFF;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] ext_word;
		word_t       base_pc;
		word_t       index_value;
		word_t       base_disp_raw;
		word_t       outer_disp_raw;
		word_t       indirect_data;
	} item_t;

	typedef struct packed {
		word_t       address;
		logic        address_kind;
		logic [3:0]  ext_bytes;
		logic [1:0]  error;
	} result_t;

	typedef struct packed {
		word_t pending_offset;
		logic  awaiting_indirect;
	} state_t;

	// Sign-extend the low word of a long
	function automatic word_t sext_word(input word_t v);
		word_t m;
		m = v & LOW_WORD_MASK;
		return {{16{m[15]}}, m[15:0]};
	endfunction

	// Sign-extend a byte
	function automatic word_t sext_byte(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

// File: rtl/pciag_if.sv
// Valid/ready channel interfaces for requests and results of the address generator.
`timescale 1ns / 1ps

interface pciag_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] ext_word;
	logic [31:0] base_pc;
	logic [31:0] index_value;
	logic [31:0] base_disp_raw;
	logic [31:0] outer_disp_raw;
	logic [31:0] indirect_data;

	modport source (
		output valid, operation, ext_word, base_pc, index_value,
		       base_disp_raw, outer_disp_raw, indirect_data,
		input  ready
	);
	modport sink (
		input  valid, operation, ext_word, base_pc, index_value,
		       base_disp_raw, outer_disp_raw, indirect_data,
		output ready
	);
endinterface

interface pciag_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        address_kind;
	logic [3:0]  ext_bytes;
	logic [1:0]  error;

	modport source (
		output valid, address, address_kind, ext_bytes, error,
		input  ready
	);
	modport sink (
		input  valid, address, address_kind, ext_bytes, error,
		output ready
	);
endinterface

// File: rtl/pciag_calc.sv
// Extension word decode and address arithmetic for one item.
`timescale 1ns / 1ps

module pciag_calc (
	input  pciag_pkg::item_t   item,
	input  pciag_pkg::state_t  state,
	output pciag_pkg::result_t result,
	output pciag_pkg::state_t  state_next
);
	import pciag_pkg::*;

	logic [15:0] ext;
	word_t       idx_sized;
	word_t       idx_scaled;
	word_t       base;
	word_t       xi;
	word_t       bd;
	word_t       od;
	logic [3:0]  bd_bytes;
	logic [3:0]  od_bytes;
	logic [1:0]  bd_size;
	logic [2:0]  sel;

	assign ext     = item.ext_word;
	assign bd_size = ext[5:4];
	assign sel     = ext[2:0];

	// Size and scale the index register
	assign idx_sized  = ext[EXT_IDX_SIZE] ? item.index_value : sext_word(item.index_value);
	assign idx_scaled = idx_sized << ext[10:9];

	assign base = ext[EXT_BASE_SUPP] ? '0 : item.base_pc;
	assign xi   = ext[EXT_IDX_SUPP] ? '0 : idx_scaled;

	// Base displacement by size; reserved size acts as null
	always_comb begin
		unique case (bd_size)
			DSZ_WORD: begin
				bd       = sext_word(item.base_disp_raw);
				bd_bytes = BYTES_WORD;
			end
			DSZ_LONG: begin
				bd       = item.base_disp_raw;
				bd_bytes = BYTES_LONG;
			end
			default: begin
				bd       = '0;
				bd_bytes = '0;
			end
		endcase
	end

	// Outer displacement by the low selection bits
	always_comb begin
		unique case (sel[1:0])
			DSZ_WORD: begin
				od       = sext_word(item.outer_disp_raw);
				od_bytes = BYTES_WORD;
			end
			DSZ_LONG: begin
				od       = item.outer_disp_raw;
				od_bytes = BYTES_LONG;
			end
			default: begin
				od       = '0;
				od_bytes = '0;
			end
		endcase
	end

	// Form the result and the next pending state
	always_comb begin
		result.address      = '0;
		result.address_kind = KIND_FINAL;
		result.ext_bytes    = '0;
		result.error        = ERR_NONE;
		state_next          = '0;
		if (item.operation == OP_DELIVER) begin
			if (!state.awaiting_indirect) begin
				result.error = ERR_STRAY_DATA;
				state_next   = state;
			end else begin
				result.address = item.indirect_data + state.pending_offset;
			end
		end else if (!ext[EXT_FULL]) begin
			// brief format: signed byte displacement, base never suppressed
			result.address   = item.base_pc + sext_byte(ext[7:0]) + idx_scaled;
			result.ext_bytes = BYTES_EXT;
		end else if (sel == SEL_NO_INDIRECT) begin
			result.address   = base + bd + xi;
			result.ext_bytes = BYTES_EXT + bd_bytes;
		end else if (sel == SEL_RESERVED) begin
			result.error     = ERR_RESERVED_SEL;
			result.ext_bytes = BYTES_EXT + bd_bytes;
		end else begin
			result.address_kind          = KIND_READ;
			result.ext_bytes             = BYTES_EXT + bd_bytes + od_bytes;
			state_next.awaiting_indirect = 1'b1;
			if (!sel[2]) begin
				// preindexed: index goes into the intermediate address
				result.address            = base + bd + xi;
				state_next.pending_offset = od;
			end else begin
				// postindexed: index is added after the fetch
				result.address            = base + bd;
				state_next.pending_offset = xi + od;
			end
		end
	end

endmodule

// File: rtl/pc_indexed_address_generator_unit.sv
// Top level of the PC-indexed effective address generator.
//
// Usage: the req channel carries start items (operation 0) that decode one
// extension word with the program counter, index register and displacement
// words, and deliver items (operation 1) that carry the long fetched from an
// intermediate address. Each item yields exactly one item on the rsp channel:
// a final effective address, or a memory read request whose answer is sent
// back as a deliver item.
// A result passes through the input register, then the result register,
// before it is offered on the rsp channel.
// Throughput: one item per cycle while the receiver takes results; the
// three-operand 32-bit adder between the two registers sets the path delay.
// The pending offset is updated as each item moves into the result register,
// so a deliver item may follow its read request directly.
// Reset clears both registers' valid flags and the pending indirection.
// When the receiver stalls, the result register holds, then the input
// register fills, and only then does req.ready drop.
`timescale 1ns / 1ps

module pc_indexed_address_generator_unit (
	input  logic              clk,
	input  logic              arst_n,
	pciag_req_if.sink         req,
	pciag_rsp_if.source       rsp
);
	import pciag_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	state_t  state_q;
	result_t result_c;
	state_t  state_c;
	logic    adv_s2;
	logic    adv_s1;

	// Advance the result stage when it is empty or being drained
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	pciag_calc u_calc (
		.item       (item_s1),
		.state      (state_q),
		.result     (result_c),
		.state_next (state_c)
	);

	// Input register: capture the request on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			item_s1.operation      <= req.operation;
			item_s1.ext_word       <= req.ext_word;
			item_s1.base_pc        <= req.base_pc;
			item_s1.index_value    <= req.index_value;
			item_s1.base_disp_raw  <= req.base_disp_raw;
			item_s1.outer_disp_raw <= req.outer_disp_raw;
			item_s1.indirect_data  <= req.indirect_data;
		end
	end

	// Result register and pending indirection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_c;
		end
	end

	// Drive the result channel
	assign rsp.valid        = valid_s2;
	assign rsp.address      = result_s2.address;
	assign rsp.address_kind = result_s2.address_kind;
	assign rsp.ext_bytes    = result_s2.ext_bytes;
	assign rsp.error        = result_s2.error;

endmodule
